/* sv/icf_pkg.sv */
package icf_pkg;

  // Field widths of the channels
  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int COEF_W     = 12;
  localparam int MASK_REGS  = 5;
  localparam int ROW_W      = COEF_W * MASK_REGS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;

  // Arithmetic widths, sized for the largest mask (5 x 5)
  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int ROWS_W = PROD_W + 3;
  localparam int SUM_W  = ROWS_W + 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW_0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW_1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW_2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW_3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ROW_4   = 3'd6;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [ROW_W-1:0] mask_row_t;
  typedef mask_row_t [MASK_REGS-1:0] mask_rows_t;

  // Forward control from the window stage to the multiply-accumulate pipe
  typedef struct packed {
    logic valid;
    logic last;
  } mac_ctl_t;

endpackage

/* sv/icf_pix_if.sv */
interface icf_pix_if;
  import icf_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;
  logic flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink (input valid, input pixel, input flush, output ready);
endinterface

/* sv/icf_res_if.sv */
interface icf_res_if;
  import icf_pkg::*;

  logic valid;
  logic ready;
  pix_t out_pixel;
  logic last_of_frame;

  modport source (output valid, output out_pixel, output last_of_frame, input ready);
  modport sink (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

/* sv/icf_cfg_if.sv */
interface icf_cfg_if;
  import icf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/image_correlation_filter_unit.sv */
// Channel  Dir  Beat payload                     Flow control
// in_ch    in   pixel[7:0], flush                valid / ready
// out_ch   out  out_pixel[7:0], last_of_frame    valid / ready
// cfg_ch   in   index[2:0], data[59:0]           valid / ready (ready tied high)
//
// Takes one input beat per clock while out_ch keeps up; the line store is read and
// written back once per beat through its single read port and single write port, which
// sets that rate. Results pass the window stage and icf_mac stages a-d and o to out_ch.
// Synchronous active-low reset clears counters, valids and registers; the line store is
// not cleared (no clearing pass), out-of-frame taps are masked instead.
// A stalled out_ch fills the pipeline, after which in_ch.ready falls.
module image_correlation_filter_unit #(
  parameter int MASK_SIZE = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  icf_pix_if.sink   in_ch,
  icf_res_if.source out_ch,
  icf_cfg_if.sink   cfg_ch
);
  import icf_pkg::*;

  localparam int HALF    = MASK_SIZE / 2;
  localparam int WN      = 2 * HALF + 1;
  localparam int LS_N    = (HALF > 0) ? 2 * HALF : 1;
  localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int D_MAX   = HALF * MAX_WIDTH + HALF;
  localparam int LW      = (D_MAX > 0) ? $clog2(D_MAX + 1) : 1;
  localparam int IRW     = FH_W + 1;
  localparam int YW      = FH_W + 1;
  localparam int XW      = CW + 1;
  localparam int RESET_W = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  typedef pix_t [LS_N-1:0] ls_word_t;

  // Configuration
  logic [CW-1:0]   w_last_r, w_last_cfg;
  logic [FH_W-1:0] h_last_r, h_last_cfg;
  logic [LW-1:0]   d_r, d_cfg;
  mask_rows_t      mask_r;
  logic [FW_W-1:0] cfg_fw;
  logic [FH_W-1:0] cfg_fh;
  logic            cfg_wr, restart;

  // Position counters
  logic [CW-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [IRW-1:0]  in_row_r, in_row_nxt;
  logic [FH_W-1:0] out_row_r, out_row_nxt;
  logic [LW-1:0]   lead_r, lead_nxt;

  // Accept stage
  logic                 acc, emit, outside, last;
  pix_t                 pix_in;
  logic [MASK_SIZE-1:0] rmask, cmask;

  // Window stage
  logic                 s1_v_r, s1_emit_r, s1_last_r, s1_fire;
  pix_t                 s1_pix_r;
  logic [CW-1:0]        s1_col_r;
  logic [MASK_SIZE-1:0] s1_rmask_r, s1_cmask_r;
  logic                 fwd_v_r;
  ls_word_t             fwd_word_r, ls_rd_r, ls_cur, ls_wr;
  ls_word_t             line_mem [MAX_WIDTH];
  pix_t [WN-1:0]        cv;
  pix_t [WN-1:0][WN-1:0] win_r, win_nxt;

  // Multiply-accumulate pipe
  mac_ctl_t                            mac_req;
  pix_t [MASK_SIZE-1:0][MASK_SIZE-1:0] mac_win;
  logic                                mac_ready;

  // Decode a configuration beat
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr  = cfg_ch.valid;
  assign restart = cfg_wr && (cfg_ch.index == REG_FRAME_WIDTH ||
                              cfg_ch.index == REG_FRAME_HEIGHT);
  assign cfg_fw  = cfg_ch.data[FW_W-1:0];
  assign cfg_fh  = cfg_ch.data[FH_W-1:0];

  always_comb begin
    if (cfg_fw == '0) begin
      w_last_cfg = '0;
    end else if (32'(cfg_fw) > 32'(MAX_WIDTH)) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(cfg_fw - 1'b1);
    end
    h_last_cfg = (cfg_fh == '0) ? '0 : cfg_fh - 1'b1;
    d_cfg      = LW'(HALF) * LW'(w_last_cfg) + LW'(2 * HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(RESET_W - 1);
      h_last_r <= '0;
      d_r      <= LW'(HALF * RESET_W + HALF);
      mask_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_FRAME_WIDTH: begin
          w_last_r <= w_last_cfg;
          d_r      <= d_cfg;
        end
        REG_FRAME_HEIGHT: h_last_r  <= h_last_cfg;
        REG_MASK_ROW_0:   mask_r[0] <= cfg_ch.data;
        REG_MASK_ROW_1:   mask_r[1] <= cfg_ch.data;
        REG_MASK_ROW_2:   mask_r[2] <= cfg_ch.data;
        REG_MASK_ROW_3:   mask_r[3] <= cfg_ch.data;
        REG_MASK_ROW_4:   mask_r[4] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Accept a beat when the window stage is free or moving on
  assign in_ch.ready = !s1_v_r || s1_fire;
  assign acc     = in_ch.valid && in_ch.ready;
  assign emit    = (lead_r == d_r);
  assign outside = in_ch.flush || (in_row_r > IRW'(h_last_r));
  assign last    = emit && (out_row_r == h_last_r) && (out_col_r == w_last_r);
  assign pix_in  = outside ? '0 : in_ch.pixel;

  // Mark mask rows and columns that fall inside the frame
  always_comb begin
    for (int m = 0; m < MASK_SIZE; m++) begin
      rmask[m] = (YW'(out_row_r) + YW'(m) >= YW'(HALF)) &&
                 (YW'(out_row_r) + YW'(m) <= YW'(h_last_r) + YW'(HALF));
      cmask[m] = (XW'(out_col_r) + XW'(m) >= XW'(HALF)) &&
                 (XW'(out_col_r) + XW'(m) <= XW'(w_last_r) + XW'(HALF));
    end
  end

  // Advance the input and output positions
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lead_nxt    = lead_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      lead_nxt    = '0;
    end else if (acc) begin
      if (in_col_r == w_last_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_r + 1'b1;
      end
      if (!emit) begin
        lead_nxt = lead_r + 1'b1;
      end else if (last) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        lead_nxt    = '0;
      end else if (out_col_r == w_last_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + 1'b1;
      end else begin
        out_col_nxt = out_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lead_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lead_r    <= lead_nxt;
    end
  end

  // Window stage: a beat with no result moves on without waiting for the pipe
  assign s1_fire = s1_v_r && (!s1_emit_r || mac_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      s1_v_r <= acc ? 1'b1 : (s1_fire ? 1'b0 : s1_v_r);
      if (acc) begin
        fwd_v_r <= s1_fire && (in_col_r == s1_col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r   <= pix_in;
      s1_col_r   <= in_col_r;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_rmask_r <= rmask;
      s1_cmask_r <= cmask;
      fwd_word_r <= ls_wr;
    end
  end

  // Line store: one word per column holds the rows above, newest in entry 0
  always_ff @(posedge clk) begin
    if (acc) begin
      ls_rd_r <= line_mem[in_col_r];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= ls_wr;
    end
  end

  // Take the word just written back when the same column is read again at once
  assign ls_cur = fwd_v_r ? fwd_word_r : ls_rd_r;

  always_comb begin
    ls_wr[0] = s1_pix_r;
    for (int k = 1; k < LS_N; k++) begin
      ls_wr[k] = ls_cur[k-1];
    end
  end

  // Column entering the window, oldest row first
  always_comb begin
    cv[WN-1] = s1_pix_r;
    for (int i = 0; i < WN - 1; i++) begin
      cv[i] = ls_cur[WN-2-i];
    end
  end

  // Shift the window one column left
  always_comb begin
    for (int i = 0; i < WN; i++) begin
      for (int j = 0; j < WN - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
      win_nxt[i][WN-1] = cv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_r <= win_nxt;
    end
  end

  // Zero the taps outside the frame
  always_comb begin
    for (int m = 0; m < MASK_SIZE; m++) begin
      for (int n = 0; n < MASK_SIZE; n++) begin
        mac_win[m][n] = (s1_rmask_r[m] && s1_cmask_r[n]) ? win_nxt[m][n] : '0;
      end
    end
  end

  assign mac_req.valid = s1_v_r && s1_emit_r;
  assign mac_req.last  = s1_last_r;

  icf_mac #(
    .MASK_SIZE (MASK_SIZE)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mac_req),
    .win       (mac_win),
    .coef_rows (mask_r),
    .ready     (mac_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lead_r <= d_r)
    else $error("lead count beyond output delay");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_col_r <= w_last_r) && (out_col_r <= w_last_r))
    else $error("column counter beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= h_last_r)
    else $error("output row beyond frame height");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last && !restart) |=>
      (in_col_r == '0 && in_row_r == '0 && out_row_r == '0 && lead_r == '0))
    else $error("counters not cleared after last beat of frame");
`endif

endmodule

/* sv/icf_mac.sv */
module icf_mac #(
  parameter int MASK_SIZE = 3
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  icf_pkg::mac_ctl_t                               req,
  input  icf_pkg::pix_t [MASK_SIZE-1:0][MASK_SIZE-1:0]    win,
  input  icf_pkg::mask_rows_t                             coef_rows,
  output logic                                            ready,
  icf_res_if.source                                       out_ch
);
  import icf_pkg::*;

  // Stage valids and payload
  logic a_v_r, b_v_r, c_v_r, d_v_r, o_v_r;
  logic a_last_r, b_last_r, c_last_r, d_last_r, o_last_r;
  pix_t [MASK_SIZE-1:0][MASK_SIZE-1:0] a_pix_r;
  logic signed [PROD_W-1:0] b_prod_r [MASK_SIZE][MASK_SIZE];
  logic signed [ROWS_W-1:0] c_row_r [MASK_SIZE];
  logic signed [SUM_W-1:0]  d_sum_r;
  pix_t                     o_pix_r;

  logic a_fire, b_fire, c_fire, d_fire, in_fire;
  logic signed [PROD_W-1:0] prod [MASK_SIZE][MASK_SIZE];
  logic signed [ROWS_W-1:0] row_sum [MASK_SIZE];
  logic signed [SUM_W-1:0]  total;
  pix_t                     sat_pix;

  // Advance each stage when the next one is empty or moving on
  assign d_fire  = d_v_r && (!o_v_r || out_ch.ready);
  assign c_fire  = c_v_r && (!d_v_r || d_fire);
  assign b_fire  = b_v_r && (!c_v_r || c_fire);
  assign a_fire  = a_v_r && (!b_v_r || b_fire);
  assign ready   = !a_v_r || a_fire;
  assign in_fire = req.valid && ready;

  // One product per mask tap
  always_comb begin
    for (int m = 0; m < MASK_SIZE; m++) begin
      for (int n = 0; n < MASK_SIZE; n++) begin
        prod[m][n] = $signed({1'b0, a_pix_r[m][n]})
                   * $signed(coef_rows[m][COEF_W*n +: COEF_W]);
      end
    end
  end

  // Sum each mask row
  always_comb begin
    for (int m = 0; m < MASK_SIZE; m++) begin
      row_sum[m] = '0;
      for (int n = 0; n < MASK_SIZE; n++) begin
        row_sum[m] = row_sum[m] + ROWS_W'(b_prod_r[m][n]);
      end
    end
  end

  // Sum the rows
  always_comb begin
    total = '0;
    for (int m = 0; m < MASK_SIZE; m++) begin
      total = total + SUM_W'(c_row_r[m]);
    end
  end

  // Drop the eight fraction bits, clamp to 0..255
  always_comb begin
    if (d_sum_r <= 0) begin
      sat_pix = '0;
    end else if (|d_sum_r[SUM_W-2:PIX_W+8]) begin
      sat_pix = '1;
    end else begin
      sat_pix = d_sum_r[PIX_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire ? 1'b1 : (a_fire ? 1'b0 : a_v_r);
      b_v_r <= a_fire ? 1'b1 : (b_fire ? 1'b0 : b_v_r);
      c_v_r <= b_fire ? 1'b1 : (c_fire ? 1'b0 : c_v_r);
      d_v_r <= c_fire ? 1'b1 : (d_fire ? 1'b0 : d_v_r);
      o_v_r <= d_fire ? 1'b1 : ((o_v_r && out_ch.ready) ? 1'b0 : o_v_r);
    end
  end

  // Payload moves with its stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix_r  <= win;
      a_last_r <= req.last;
    end
    if (a_fire) begin
      b_prod_r <= prod;
      b_last_r <= a_last_r;
    end
    if (b_fire) begin
      c_row_r  <= row_sum;
      c_last_r <= b_last_r;
    end
    if (c_fire) begin
      d_sum_r  <= total;
      d_last_r <= c_last_r;
    end
    if (d_fire) begin
      o_pix_r  <= sat_pix;
      o_last_r <= d_last_r;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.out_pixel     = o_pix_r;
  assign out_ch.last_of_frame = o_last_r;

endmodule
